// File: src/nearest_neighbor_pixel_replicator_top_assert.svh
// Assertion macros for the nearest-neighbor pixel replicator.
`ifndef NEAREST_NEIGHBOR_PIXEL_REPLICATOR_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_PIXEL_REPLICATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NNPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define NNPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nnpr_pkg.sv
// Shared constants and helper functions for the nearest-neighbor pixel replicator.
package nnpr_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int MAX_SCALE = 8;

  localparam int DIM_W   = 13;  // configuration register width
  localparam int CNT_W   = 12;  // source column and row counters
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 24;
  localparam int NUM_W   = 25;  // dividend: (coord + 1) * dst size
  localparam int QUO_W   = 13;  // quotient bits, span bounds up to MAX_DIM
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int LIM_W   = DIM_W + $clog2(MAX_SCALE);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 3'd4;

  // Source size: zero becomes one, clip to MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_src(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // Destination size: zero takes the source size, clip to MAX_DIM and MAX_SCALE * source.
  function automatic logic [DIM_W-1:0] eff_dst(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] s);
    logic [LIM_W-1:0] lim;
    logic [DIM_W-1:0] r;
    lim = LIM_W'(s) * LIM_W'(MAX_SCALE);
    r = (v == '0) ? s : v;
    if (r > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    if (LIM_W'(r) > lim) r = lim[DIM_W-1:0];
    return r;
  endfunction

endpackage

// File: src/nearest_neighbor_pixel_replicator_top.sv
// Nearest-neighbor scaler: per source pixel, one write per covered destination cell.
// A new pixel is taken only while idle, so it waits until the last one is done; each pixel
//   gives n writes (1..64), or none. The four span bounds go one after another through a shared
//   multiplier and a 13-step divider, and a write that waits on out_tready holds the pixel.
// Reset (rst_n low, synchronous): registers to defaults, counters to 0, idle.
`include "nearest_neighbor_pixel_replicator_top_assert.svh"

module nearest_neighbor_pixel_replicator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nnpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnpr_pkg::DIM_W-1:0]        cfg_data,
  // source pixels
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] pixel_color
  // destination writes
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [55:0]                       out_tdata,  // [23:0] dest_address, [55:24] write_color
  output logic                              out_tlast   // last_write
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_RBASE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam int DIM_W  = nnpr_pkg::DIM_W;
  localparam int CNT_W  = nnpr_pkg::CNT_W;
  localparam int NUM_W  = nnpr_pkg::NUM_W;
  localparam int QUO_W  = nnpr_pkg::QUO_W;
  localparam int STEP_W = nnpr_pkg::STEP_W;
  localparam int ADDR_W = nnpr_pkg::ADDR_W;
  localparam int COLOR_W = nnpr_pkg::COLOR_W;
  localparam int PROD_W = 2 * DIM_W;

  // configuration registers
  logic [DIM_W-1:0] src_width_r, src_height_r, dst_width_r, dst_height_r, row_pitch_r;

  // control and datapath registers
  logic [2:0]         state_r, state_nxt;
  logic [1:0]         sel_r, sel_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [NUM_W-1:0]   dsh_r, dsh_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [QUO_W-1:0]   x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [CNT_W-1:0]   src_col_r, src_col_nxt, src_row_r, src_row_nxt;
  logic [CNT_W-1:0]   cur_col_r, cur_col_nxt, cur_row_r, cur_row_nxt;
  logic [DIM_W-1:0]   sw_r, sw_nxt, sh_r, sh_nxt, dw_r, dw_nxt, dh_r, dh_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [QUO_W-1:0]   c_r, c_nxt, r_r, r_nxt;
  logic [ADDR_W-1:0]  row_base_r, row_base_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic               out_tlast_r, out_tlast_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;

  // combinational helpers
  logic [DIM_W-1:0]  sw_eff, sh_eff;
  logic [CNT_W-1:0]  col_n, row_n;
  logic [DIM_W-1:0]  col_inc, row_inc;
  logic [DIM_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] product;
  logic              div_ge;
  logic [QUO_W-1:0]  quo_step;
  logic              accept;
  logic              load_out;
  logic              col_end, row_end;
  logic              span_ok, cursor_in;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {out_color_r, out_addr_r};

  assign sw_eff = nnpr_pkg::eff_src(src_width_r);
  assign sh_eff = nnpr_pkg::eff_src(src_height_r);

  // Wrap counters that the configuration has left out of range.
  assign col_n   = ({1'b0, src_col_r} >= sw_eff) ? '0 : src_col_r;
  assign row_n   = ({1'b0, src_row_r} >= sh_eff) ? '0 : src_row_r;
  assign col_inc = {1'b0, col_n} + DIM_W'(1);
  assign row_inc = {1'b0, row_n} + DIM_W'(1);

  // Shared multiplier: span numerators, then the first row's base address.
  always_comb begin
    if (state_r == ST_RBASE) begin
      mul_a = y0_r;
      mul_b = row_pitch_r;
    end else begin
      mul_a = (sel_r[1] ? {1'b0, cur_row_r} : {1'b0, cur_col_r}) + DIM_W'(sel_r[0]);
      mul_b = sel_r[1] ? dh_r : dw_r;
    end
  end
  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  // One restoring-division step per cycle.
  assign div_ge   = (num_r >= dsh_r);
  assign quo_step = {quo_r[QUO_W-2:0], div_ge};

  assign load_out = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  assign col_end  = (c_r + QUO_W'(1) == x1_r);
  assign row_end  = (r_r + QUO_W'(1) == y1_r);

  assign span_ok   = (x1_r >= x0_r) && (y1_r >= y0_r) &&
                     ((x1_r - x0_r) <= QUO_W'(nnpr_pkg::MAX_SCALE)) &&
                     ((y1_r - y0_r) <= QUO_W'(nnpr_pkg::MAX_SCALE));
  assign cursor_in = (c_r >= x0_r) && (c_r < x1_r) && (r_r >= y0_r) && (r_r < y1_r);

  always_comb begin
    state_nxt      = state_r;
    sel_nxt        = sel_r;
    step_nxt       = step_r;
    num_nxt        = num_r;
    dsh_nxt        = dsh_r;
    quo_nxt        = quo_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    y0_nxt         = y0_r;
    y1_nxt         = y1_r;
    src_col_nxt    = src_col_r;
    src_row_nxt    = src_row_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    sw_nxt         = sw_r;
    sh_nxt         = sh_r;
    dw_nxt         = dw_r;
    dh_nxt         = dh_r;
    color_nxt      = color_r;
    c_nxt          = c_r;
    r_nxt          = r_r;
    row_base_nxt   = row_base_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tlast_nxt  = out_tlast_r;
    out_addr_nxt   = out_addr_r;
    out_color_nxt  = out_color_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          color_nxt   = in_tdata;
          sw_nxt      = sw_eff;
          sh_nxt      = sh_eff;
          dw_nxt      = nnpr_pkg::eff_dst(dst_width_r, sw_eff);
          dh_nxt      = nnpr_pkg::eff_dst(dst_height_r, sh_eff);
          cur_col_nxt = col_n;
          cur_row_nxt = row_n;
          sel_nxt     = 2'd0;
          // advance the raster position
          if (col_inc >= sw_eff) begin
            src_col_nxt = '0;
            src_row_nxt = (row_inc >= sh_eff) ? '0 : row_inc[CNT_W-1:0];
          end else begin
            src_col_nxt = col_inc[CNT_W-1:0];
            src_row_nxt = row_n;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        num_nxt   = product[NUM_W-1:0];
        dsh_nxt   = {(sel_r[1] ? sh_r : sw_r), (QUO_W-1)'(0)};
        quo_nxt   = '0;
        step_nxt  = STEP_W'(QUO_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        num_nxt  = div_ge ? (num_r - dsh_r) : num_r;
        dsh_nxt  = dsh_r >> 1;
        quo_nxt  = quo_step;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          case (sel_r)
            2'd0:    x0_nxt = quo_step;
            2'd1:    x1_nxt = quo_step;
            2'd2:    y0_nxt = quo_step;
            default: y1_nxt = quo_step;
          endcase
          if (sel_r == 2'd3) begin
            state_nxt = ST_RBASE;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_RBASE: begin
        // drop pixels that cover no destination cell
        if (x0_r == x1_r || y0_r == y1_r) begin
          state_nxt = ST_IDLE;
        end else begin
          row_base_nxt = product[ADDR_W-1:0];
          c_nxt        = x0_r;
          r_nxt        = y0_r;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_tvalid_nxt = 1'b1;
          out_addr_nxt   = row_base_r + ADDR_W'(c_r);
          out_color_nxt  = color_r;
          out_tlast_nxt  = col_end && row_end;
          if (col_end) begin
            c_nxt        = x0_r;
            r_nxt        = r_r + QUO_W'(1);
            row_base_nxt = row_base_r + ADDR_W'(row_pitch_r);
            if (row_end) state_nxt = ST_IDLE;
          end else begin
            c_nxt = c_r + QUO_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(1);
      src_height_r <= DIM_W'(1);
      dst_width_r  <= '0;
      dst_height_r <= '0;
      row_pitch_r  <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nnpr_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        nnpr_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data;
        nnpr_pkg::REG_DST_WIDTH:  dst_width_r  <= cfg_data;
        nnpr_pkg::REG_DST_HEIGHT: dst_height_r <= cfg_data;
        nnpr_pkg::REG_ROW_PITCH:  row_pitch_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sel_r        <= 2'd0;
      src_col_r    <= '0;
      src_row_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sel_r        <= sel_nxt;
      src_col_r    <= src_col_nxt;
      src_row_r    <= src_row_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    num_r       <= num_nxt;
    dsh_r       <= dsh_nxt;
    quo_r       <= quo_nxt;
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    y0_r        <= y0_nxt;
    y1_r        <= y1_nxt;
    cur_col_r   <= cur_col_nxt;
    cur_row_r   <= cur_row_nxt;
    sw_r        <= sw_nxt;
    sh_r        <= sh_nxt;
    dw_r        <= dw_nxt;
    dh_r        <= dh_nxt;
    color_r     <= color_nxt;
    c_r         <= c_nxt;
    r_r         <= r_nxt;
    row_base_r  <= row_base_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_addr_r  <= out_addr_nxt;
    out_color_r <= out_color_nxt;
  end

  `NNPR_ASSERT_IMPL(a_span_order, state_r == ST_RBASE, span_ok, "span bounds out of order or too wide")
  `NNPR_ASSERT_IMPL(a_emit_inside, state_r == ST_EMIT, cursor_in, "write cursor outside the pixel span")
  `NNPR_ASSERT_NEXT(a_last_ends, load_out && col_end && row_end, out_tvalid_r && out_tlast_r && (state_r == ST_IDLE), "final write did not close the pixel")

endmodule

// File: tb/sv/nearest_neighbor_pixel_replicator_top_tb.sv
// Self-checking testbench for the nearest-neighbor pixel replicator: directed plan, random phases.
`timescale 1ns / 1ps

module nearest_neighbor_pixel_replicator_top_tb;

  localparam int DIM_W     = nnpr_pkg::DIM_W;
  localparam int CFG_IDX_W = nnpr_pkg::CFG_IDX_W;
  localparam int ADDR_W    = nnpr_pkg::ADDR_W;
  localparam int COLOR_W   = nnpr_pkg::COLOR_W;
  localparam int MAX_DIM   = nnpr_pkg::MAX_DIM;
  localparam int MAX_SCALE = nnpr_pkg::MAX_SCALE;

  localparam int REG_MAX       = (1 << DIM_W) - 1;
  localparam int IDLE_TAIL     = 100;       // covers the span computation of a pixel that writes nothing
  localparam int TALL_ITEMS    = 140;       // enough source rows to reach the upper address bits
  localparam int NUM_PHASES    = 7;
  localparam int MAX_REPORTED  = 10;
  localparam int RUN_LIMIT_NS  = 10_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST        = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } dest_write_t;

  typedef enum logic { ROW_CFG, ROW_PIXEL } plan_kind_t;

  typedef struct {
    plan_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     val;
    logic [COLOR_W-1:0]   color;
    bit                   typed;   // single write at addr, known by inspection
    logic [ADDR_W-1:0]    addr;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;   // [31:0] pixel_color
  logic                 out_tvalid;
  logic                 out_tready;
  logic [55:0]          out_tdata;  // [23:0] dest_address, [55:24] write_color
  logic                 out_tlast;  // last_write

  // shadow registers and source counters of the scaler
  logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q, pitch_q;
  int               col_q, row_q;

  dest_write_t predicted_cells[$];
  dest_write_t pending_writes[$];
  plan_row_t   plan[$];

  int mismatch_count;
  bit quiet_q;
  bit cfg_open;
  bit pixels_in_flight;

  nearest_neighbor_pixel_replicator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL nearest_neighbor_pixel_replicator_top");
    $finish;
  end

  function automatic int clip_src(input int v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int clip_dst(input int v, input int s);
    int r;
    r = (v == 0) ? s : v;
    if (r > MAX_DIM) r = MAX_DIM;
    if (r > s * MAX_SCALE) r = s * MAX_SCALE;
    return r;
  endfunction

  // Fill predicted_cells with the writes of one pixel, rows outer, columns inner.
  function automatic void replicate_pixel(input logic [COLOR_W-1:0] color);
    int sw, sh, dw, dh, x0, x1, y0, y1;
    dest_write_t w;
    sw = clip_src(int'(src_w_q));
    sh = clip_src(int'(src_h_q));
    dw = clip_dst(int'(dst_w_q), sw);
    dh = clip_dst(int'(dst_h_q), sh);
    predicted_cells.delete();
    // counters may be left beyond a shrunken image
    if (col_q >= sw) col_q = 0;
    if (row_q >= sh) row_q = 0;
    x0 = (col_q * dw) / sw;
    x1 = ((col_q + 1) * dw) / sw;
    y0 = (row_q * dh) / sh;
    y1 = ((row_q + 1) * dh) / sh;
    for (int r = y0; r < y1; r++) begin
      for (int c = x0; c < x1; c++) begin
        w.addr  = ADDR_W'(c + r * int'(pitch_q));
        w.color = color;
        w.last  = 1'b0;
        predicted_cells.push_back(w);
      end
    end
    if (predicted_cells.size() > 0) predicted_cells[predicted_cells.size() - 1].last = 1'b1;
    col_q++;
    if (col_q >= sw) begin
      col_q = 0;
      row_q++;
      if (row_q >= sh) row_q = 0;
    end
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [DIM_W-1:0] val);
    plan_row_t p;
    p.kind  = ROW_CFG;
    p.idx   = idx;
    p.val   = val;
    p.color = '0;
    p.typed = 1'b0;
    p.addr  = '0;
    return p;
  endfunction

  function automatic plan_row_t pixel_row(input logic [COLOR_W-1:0] color, input bit typed,
                                          input logic [ADDR_W-1:0] addr);
    plan_row_t p;
    p.kind  = ROW_PIXEL;
    p.idx   = nnpr_pkg::REG_SRC_WIDTH;
    p.val   = '0;
    p.color = color;
    p.typed = typed;
    p.addr  = addr;
    return p;
  endfunction

  function automatic logic [DIM_W-1:0] pick_src();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIM_W'(MAX_DIM);
      2: return DIM_W'($urandom_range(MAX_DIM + 1, REG_MAX));
      default: return DIM_W'($urandom_range(1, MAX_SCALE));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dst(input logic [DIM_W-1:0] src);
    int span;
    span = clip_src(int'(src)) * MAX_SCALE + 4;
    if (span > REG_MAX) span = REG_MAX;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DIM_W'(MAX_DIM);
      2: return DIM_W'($urandom_range(MAX_DIM + 1, REG_MAX));
      default: return DIM_W'($urandom_range(1, span));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("mismatch %s: expected %h, got %h", what, want_v, got_v);
  endtask

  // Drain everything in flight, then let the block finish a pixel that writes nothing.
  task automatic settle();
    if (pixels_in_flight) begin
      in_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clk);
      repeat (IDLE_TAIL) @(posedge clk);
      pixels_in_flight = 1'b0;
    end
  endtask

  // Leave cfg_valid high so back-to-back writes need a single assignment per step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_open = 1'b1;
    case (idx)
      nnpr_pkg::REG_SRC_WIDTH:  src_w_q = val;
      nnpr_pkg::REG_SRC_HEIGHT: src_h_q = val;
      nnpr_pkg::REG_DST_WIDTH:  dst_w_q = val;
      nnpr_pkg::REG_DST_HEIGHT: dst_h_q = val;
      nnpr_pkg::REG_ROW_PITCH:  pitch_q = val;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [COLOR_W-1:0] color, input bit typed,
                            input logic [ADDR_W-1:0] typed_addr);
    int gap;
    dest_write_t w;
    gap = quiet_q ? 0 : $urandom_range(0, 3);
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= color;
    do @(posedge clk); while (!in_tready);
    pixels_in_flight = 1'b1;
    replicate_pixel(color);
    if (typed) begin
      w.addr  = typed_addr;
      w.color = color;
      w.last  = 1'b1;
      pending_writes.push_back(w);
    end else begin
      foreach (predicted_cells[i]) pending_writes.push_back(predicted_cells[i]);
    end
  endtask

  always @(posedge clk) begin : check_writes
    dest_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        flag_mismatch("write with none pending, dest_address", '0,
                      32'(out_tdata[ADDR_W-1:0]));
      end else begin
        want = pending_writes.pop_front();
        if (want.addr !== out_tdata[ADDR_W-1:0])
          flag_mismatch("dest_address", 32'(want.addr), 32'(out_tdata[ADDR_W-1:0]));
        if (want.color !== out_tdata[ADDR_W +: COLOR_W])
          flag_mismatch("write_color", want.color, out_tdata[ADDR_W +: COLOR_W]);
        if (want.last !== out_tlast)
          flag_mismatch("last_write", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  initial begin : drain_writes
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = quiet_q ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    int n_items;
    logic [DIM_W-1:0] sw_v, sh_v;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    mismatch_count   = 0;
    quiet_q          = 1'b0;
    cfg_open         = 1'b0;
    pixels_in_flight = 1'b0;
    src_w_q = DIM_W'(1);
    src_h_q = DIM_W'(1);
    dst_w_q = '0;
    dst_h_q = '0;
    pitch_q = DIM_W'(1);
    col_q   = 0;
    row_q   = 0;

    // defaults after reset: one write at address 0 per pixel
    plan.push_back(pixel_row(32'h0000_0000, 1'b1, 24'd0));
    plan.push_back(pixel_row(32'hFFFF_FFFF, 1'b1, 24'd0));
    // zero source width behaves as one
    plan.push_back(cfg_row(nnpr_pkg::REG_SRC_WIDTH, DIM_W'(0)));
    plan.push_back(pixel_row(32'h5A5A_A5A5, 1'b1, 24'd0));
    // oversized source height clips to MAX_DIM, default destination height follows it
    plan.push_back(cfg_row(nnpr_pkg::REG_SRC_HEIGHT, DIM_W'(REG_MAX)));
    plan.push_back(cfg_row(nnpr_pkg::REG_DST_HEIGHT, DIM_W'(0)));
    plan.push_back(pixel_row(32'h1234_5678, 1'b1, 24'd0));
    plan.push_back(pixel_row(32'h8765_4321, 1'b1, 24'd1));
    // zero pitch folds every row onto row zero
    plan.push_back(cfg_row(nnpr_pkg::REG_ROW_PITCH, DIM_W'(0)));
    plan.push_back(pixel_row(32'hC0FF_EE00, 1'b1, 24'd0));
    // oversized destination clips to eight times the source: 64 writes per pixel
    plan.push_back(cfg_row(nnpr_pkg::REG_SRC_WIDTH, DIM_W'(2)));
    plan.push_back(cfg_row(nnpr_pkg::REG_SRC_HEIGHT, DIM_W'(2)));
    plan.push_back(cfg_row(nnpr_pkg::REG_DST_WIDTH, DIM_W'(REG_MAX)));
    plan.push_back(cfg_row(nnpr_pkg::REG_DST_HEIGHT, DIM_W'(REG_MAX)));
    plan.push_back(pixel_row(32'h0102_0304, 1'b0, '0));
    plan.push_back(cfg_row(nnpr_pkg::REG_ROW_PITCH, DIM_W'(REG_MAX)));
    plan.push_back(pixel_row(32'hF0E0_D0C0, 1'b0, '0));
    plan.push_back(pixel_row(32'h0F0F_0F0F, 1'b0, '0));
    plan.push_back(pixel_row(32'hF0F0_F0F0, 1'b0, '0));
    // heavy downscale: most pixels cover no destination cell
    plan.push_back(cfg_row(nnpr_pkg::REG_SRC_WIDTH, DIM_W'(MAX_DIM)));
    plan.push_back(cfg_row(nnpr_pkg::REG_SRC_HEIGHT, DIM_W'(1)));
    plan.push_back(cfg_row(nnpr_pkg::REG_DST_WIDTH, DIM_W'(1)));
    plan.push_back(cfg_row(nnpr_pkg::REG_DST_HEIGHT, DIM_W'(0)));
    plan.push_back(cfg_row(nnpr_pkg::REG_ROW_PITCH, DIM_W'(1)));
    for (int i = 0; i < 4; i++) plan.push_back(pixel_row(32'(i) * 32'h1111_1111, 1'b0, '0));
    // writes to unused indexes change nothing
    plan.push_back(cfg_row(CFG_IDX_SPARE_FIRST, DIM_W'(REG_MAX)));
    plan.push_back(cfg_row(CFG_IDX_LAST, DIM_W'(0)));
    plan.push_back(pixel_row(32'hDEAD_BEEF, 1'b0, '0));
    // shrink the width under a running column: it restarts at zero
    plan.push_back(cfg_row(nnpr_pkg::REG_SRC_WIDTH, DIM_W'(3)));
    plan.push_back(cfg_row(nnpr_pkg::REG_DST_WIDTH, DIM_W'(0)));
    plan.push_back(pixel_row(32'hAAAA_5555, 1'b1, 24'd0));
    plan.push_back(pixel_row(32'h5555_AAAA, 1'b1, 24'd1));
    plan.push_back(cfg_row(nnpr_pkg::REG_DST_WIDTH, DIM_W'(100)));
    plan.push_back(pixel_row(32'h7F80_01FE, 1'b0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].val);
      else send_pixel(plan[i].color, plan[i].typed, plan[i].addr);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        // tall 8x upscale with maximum pitch: addresses climb into the upper address bits
        write_reg(nnpr_pkg::REG_SRC_WIDTH, DIM_W'($urandom_range(0, 1)));
        write_reg(nnpr_pkg::REG_SRC_HEIGHT, DIM_W'(MAX_DIM / MAX_SCALE));
        write_reg(nnpr_pkg::REG_DST_WIDTH, '0);
        write_reg(nnpr_pkg::REG_DST_HEIGHT, DIM_W'(MAX_DIM));
        write_reg(nnpr_pkg::REG_ROW_PITCH, DIM_W'(REG_MAX));
        n_items = TALL_ITEMS;
      end else begin
        sw_v = pick_src();
        sh_v = pick_src();
        write_reg(nnpr_pkg::REG_SRC_WIDTH, sw_v);
        write_reg(nnpr_pkg::REG_SRC_HEIGHT, sh_v);
        if ($urandom_range(0, 2) == 0)
          write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_FIRST, CFG_IDX_LAST)),
                    DIM_W'($urandom_range(0, REG_MAX)));
        write_reg(nnpr_pkg::REG_DST_WIDTH, pick_dst(sw_v));
        write_reg(nnpr_pkg::REG_DST_HEIGHT, pick_dst(sh_v));
        case ($urandom_range(0, 3))
          0: write_reg(nnpr_pkg::REG_ROW_PITCH, '0);
          1: write_reg(nnpr_pkg::REG_ROW_PITCH, DIM_W'(REG_MAX));
          default: write_reg(nnpr_pkg::REG_ROW_PITCH, DIM_W'($urandom_range(1, 64)));
        endcase
        n_items = $urandom_range(8, 16);
      end
      quiet_q = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_items; i++) send_pixel($urandom(), 1'b0, '0);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASS nearest_neighbor_pixel_replicator_top");
    end else begin
      $display("FAIL nearest_neighbor_pixel_replicator_top");
    end
    $finish;
  end

endmodule
